[hdl/pta_pkg.sv]
package pta_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_DATA_W = 31;
   localparam int CSR_INDEX_W = 1;
   localparam logic [30:0] THRESHOLD_RESET = 31'd120000;
   // entry word: key, strength, last seen, gone, session, total
   localparam int ENTRY_W = 64 + 8 + 32 + 1 + 16 + 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTIFY = 1'd1;

   localparam logic [2:0] OUTCOME_UPDATED = 3'd0;
   localparam logic [2:0] OUTCOME_APPENDED = 3'd1;
   localparam logic [2:0] OUTCOME_REUSED = 3'd2;
   localparam logic [2:0] OUTCOME_REPLACED = 3'd3;
   localparam logic [2:0] OUTCOME_SWEPT = 3'd4;

   localparam logic ACTION_SIGHTING = 1'b0;
   localparam logic ACTION_SWEEP = 1'b1;

   typedef struct packed {
      logic action;
      logic [63:0] peer_key;
      logic signed [7:0] signal_strength;
      logic [31:0] now_ms;
      logic [15:0] session_count;
      logic [15:0] total_count;
   } req_type;

   typedef struct packed {
      logic [5:0] slot;
      logic [2:0] outcome;
      logic notify_friend;
      logic [6:0] peer_total;
      logic [15:0] last_session_count;
      logic [15:0] last_total_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [7:0] strength;
      logic [31:0] last_seen;
      logic gone;
      logic [15:0] session;
      logic [15:0] total;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_VICTIM,
      ST_SWEEP,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

[hdl/pta_ram.sv]
module pta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hdl/peer_table_with_aging_top.sv]
// channel  ports                            direction
// request  start, busy, req_data            in
// result   rsp_valid, rsp_data              out (one cycle, no stall)
// config   csr_wr_en, csr_index, csr_wdata  in
//
// a request takes one scan of the table per pass, one entry read a cycle from
// the single entry memory: a sighting up to two passes (key match, then gone or
// oldest search), a sweep one pass with write-back. busy is high until the result
// strobe cycle and low during it. reset is synchronous and clears the count and
// recent totals; entry contents need no clearing since only entries below the
// count are ever read. results cannot be held off.
module peer_table_with_aging_top import pta_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;
   req_type req_ff;
   logic [30:0] threshold_ff;
   logic notify_en_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0] recent_session_ff, recent_session_in;
   logic [15:0] recent_total_ff, recent_total_in;
   logic [CNT_W-1:0] scan_ff, scan_in;       // address issued
   logic rd_valid_ff, rd_valid_in;          // read data belongs to scan_ff - 1
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [2:0] outcome_ff, outcome_in;
   logic [31:0] best_ff, best_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   entry_type ram_wr_data, ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_raw;

   logic [31:0] age;
   logic aged_out;
   logic scan_end;
   logic full;

   pta_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entries (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_raw)
   );
   assign ram_rd_data = entry_type'(ram_rd_raw);

   assign full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign age = req_ff.now_ms - ram_rd_data.last_seen;
   assign aged_out = !age[31] && (age[30:0] > threshold_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         notify_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_NOTIFY:    notify_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      scan_end = rd_valid_ff && (CNT_W'(rd_idx_ff) + 1'b1 >= scan_ff)
                 && (scan_ff >= (state_ff == ST_VICTIM ? CNT_W'(TABLE_DEPTH) : count_ff));
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.action == ACTION_SWEEP) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SWEEP;
               end else begin
                  state_in = (count_ff == '0) ? ST_WRITE : ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            if (rd_valid_ff && ram_rd_data.key == req_ff.peer_key) begin
               state_in = ST_WRITE;
            end else if (scan_end) begin
               state_in = full ? ST_VICTIM : ST_WRITE;
            end
         end
         ST_VICTIM: begin
            if (rd_valid_ff && ram_rd_data.gone) begin
               state_in = ST_WRITE;
            end else if (scan_end) begin
               state_in = ST_WRITE;
            end
         end
         ST_SWEEP: begin
            if (scan_end) state_in = ST_DONE;
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      scan_in = scan_ff;
      rd_valid_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      found_in = found_ff;
      slot_in = slot_ff;
      outcome_in = outcome_ff;
      best_in = best_ff;
      count_in = count_ff;
      recent_session_in = recent_session_ff;
      recent_total_in = recent_total_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      ram_rd_addr = scan_ff[IDX_W-1:0];
      ram_wr_en = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            found_in = 1'b0;
            slot_in = '0;
            best_in = '1;
            if (start) begin
               ram_rd_addr = '0;
               scan_in = CNT_W'(1);
               rd_valid_in = 1'b1;
               rd_idx_in = '0;
               if (req_data.action == ACTION_SWEEP) begin
                  outcome_in = OUTCOME_SWEPT;
               end else if (count_ff == '0) begin
                  outcome_in = OUTCOME_APPENDED;
               end
            end
         end
         ST_MATCH: begin
            // key compare, one entry a cycle
            if (scan_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (rd_valid_ff && ram_rd_data.key == req_ff.peer_key) begin
               slot_in = rd_idx_ff;
               outcome_in = OUTCOME_UPDATED;
               rd_valid_in = 1'b0;
            end else if (scan_end) begin
               if (full) begin
                  // restart scan for gone or oldest entry
                  ram_rd_addr = '0;
                  scan_in = CNT_W'(1);
                  rd_valid_in = 1'b1;
                  rd_idx_in = '0;
                  outcome_in = OUTCOME_REPLACED;
               end else begin
                  slot_in = count_ff[IDX_W-1:0];
                  outcome_in = OUTCOME_APPENDED;
               end
            end
         end
         ST_VICTIM: begin
            if (scan_ff < CNT_W'(TABLE_DEPTH)) begin
               rd_valid_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (ram_rd_data.gone) begin
                  slot_in = rd_idx_ff;
                  outcome_in = OUTCOME_REUSED;
                  rd_valid_in = 1'b0;
               end else if (rd_idx_ff == '0 || ram_rd_data.last_seen < best_ff) begin
                  // strict less keeps the first minimum
                  best_in = ram_rd_data.last_seen;
                  slot_in = rd_idx_ff;
               end
            end
         end
         ST_SWEEP: begin
            // read each entry, write aged-out ones back with gone mark
            if (scan_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (rd_valid_ff && aged_out) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = rd_idx_ff;
               ram_wr_data = ram_rd_data;
               ram_wr_data.gone = 1'b1;
            end
            outcome_in = OUTCOME_SWEPT;
            slot_in = '0;
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = slot_ff;
            ram_wr_data.key = req_ff.peer_key;
            ram_wr_data.strength = req_ff.signal_strength;
            ram_wr_data.last_seen = req_ff.now_ms;
            ram_wr_data.gone = 1'b0;
            ram_wr_data.session = req_ff.session_count;
            ram_wr_data.total = req_ff.total_count;
            recent_session_in = req_ff.session_count;
            recent_total_in = req_ff.total_count;
            if (outcome_ff == OUTCOME_APPENDED) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.slot = 6'(slot_ff);
            rsp_in.outcome = outcome_ff;
            rsp_in.notify_friend = (outcome_ff != OUTCOME_UPDATED)
                                   && (outcome_ff != OUTCOME_SWEPT)
                                   && !full && notify_en_ff;
            rsp_in.peer_total = 7'(count_ff);
            rsp_in.last_session_count = recent_session_ff;
            rsp_in.last_total_count = recent_total_ff;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         recent_session_ff <= '0;
         recent_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         recent_session_ff <= recent_session_in;
         recent_total_ff <= recent_total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
      scan_ff <= scan_in;
      rd_idx_ff <= rd_idx_in;
      found_ff <= found_in;
      slot_ff <= slot_in;
      outcome_ff <= outcome_in;
      best_ff <= best_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("occupied count beyond table depth");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_DONE)
      else $error("result strobe without completion");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("occupied count moved by more than one");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;
   import pta_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count = 0;
   int accepted_count = 0;
   bit quiet = 1'b0;
   logic [31:0] now_t = 32'd1000;
   logic [63:0] key_pool [96];

   always #10 clock = ~clock;

   peer_table_with_aging_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // one line per mismatch
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   class peer_scoreboard;
      logic [63:0] key [TABLE_DEPTH];
      logic [31:0] seen [TABLE_DEPTH];
      bit gone [TABLE_DEPTH];
      int occupied;
      logic [15:0] recent_session;
      logic [15:0] recent_total;
      logic [30:0] threshold;
      bit notify_en;
      rsp_type pending [$];

      function new();
         occupied = 0;
         recent_session = '0;
         recent_total = '0;
         threshold = THRESHOLD_RESET;
         notify_en = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         if (idx == CSR_THRESHOLD) threshold = v;
         else if (idx == CSR_NOTIFY) notify_en = v[0];
      endfunction

      // work out the result of one accepted request
      function void note_request(req_type r);
         rsp_type e;
         logic [31:0] age;
         logic [31:0] best;
         bit found;
         e = '0;
         found = 1'b0;
         if (r.action == ACTION_SWEEP) begin
            for (int i = 0; i < occupied; i++) begin
               age = r.now_ms - seen[i];
               if (!age[31] && age > {1'b0, threshold}) gone[i] = 1'b1;
            end
            e.outcome = OUTCOME_SWEPT;
         end else begin
            for (int i = 0; i < occupied && !found; i++)
               if (key[i] == r.peer_key) begin
                  found = 1'b1;
                  e.slot = 6'(i);
               end
            if (found) begin
               e.outcome = OUTCOME_UPDATED;
            end else if (occupied < TABLE_DEPTH) begin
               e.slot = 6'(occupied);
               occupied++;
               e.outcome = OUTCOME_APPENDED;
            end else begin
               for (int i = 0; i < TABLE_DEPTH && !found; i++)
                  if (gone[i]) begin
                     found = 1'b1;
                     e.slot = 6'(i);
                  end
               if (found) begin
                  e.outcome = OUTCOME_REUSED;
               end else begin
                  // oldest entry, lowest index wins a tie
                  best = seen[0];
                  e.slot = '0;
                  for (int i = 1; i < TABLE_DEPTH; i++)
                     if (seen[i] < best) begin
                        best = seen[i];
                        e.slot = 6'(i);
                     end
                  e.outcome = OUTCOME_REPLACED;
               end
            end
            key[e.slot] = r.peer_key;
            seen[e.slot] = r.now_ms;
            gone[e.slot] = 1'b0;
            recent_session = r.session_count;
            recent_total = r.total_count;
            e.notify_friend = (e.outcome != OUTCOME_UPDATED) && (occupied < TABLE_DEPTH)
                              && notify_en;
         end
         e.peer_total = 7'(occupied);
         e.last_session_count = recent_session;
         e.last_total_count = recent_total;
         pending = {pending, e};
      endfunction

      task check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", 64'(got), '0);
         end else begin
            e = pending.pop_front();
            if (got.slot !== e.slot) report_mismatch("slot", 64'(got.slot), 64'(e.slot));
            if (got.outcome !== e.outcome)
               report_mismatch("outcome", 64'(got.outcome), 64'(e.outcome));
            if (got.notify_friend !== e.notify_friend)
               report_mismatch("notify_friend", 64'(got.notify_friend),
                               64'(e.notify_friend));
            if (got.peer_total !== e.peer_total)
               report_mismatch("peer_total", 64'(got.peer_total), 64'(e.peer_total));
            if (got.last_session_count !== e.last_session_count)
               report_mismatch("last_session_count", 64'(got.last_session_count),
                               64'(e.last_session_count));
            if (got.last_total_count !== e.last_total_count)
               report_mismatch("last_total_count", 64'(got.last_total_count),
                               64'(e.last_total_count));
         end
      endtask
   endclass

   peer_scoreboard sb = new();

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_data);
            accepted_count++;
         end
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   // present one request and hold it until taken
   task automatic send_request(req_type r);
      int n;
      if (!quiet && $urandom_range(99) < 27) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      n = accepted_count;
      wait (accepted_count != n);
   endtask

   // drain all results before touching registers
   task automatic drain;
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type sighting(logic [63:0] k, logic [31:0] t);
      req_type r;
      r.action = ACTION_SIGHTING;
      r.peer_key = k;
      r.signal_strength = 8'($urandom);
      r.now_ms = t;
      r.session_count = 16'($urandom);
      r.total_count = 16'($urandom);
      return r;
   endfunction

   function automatic req_type sweep(logic [31:0] t);
      req_type r;
      r = sighting({$urandom, $urandom}, t);
      r.action = ACTION_SWEEP;
      return r;
   endfunction

   // mostly pool keys so updates and aging happen, some fresh keys
   task automatic random_items(int count);
      req_type r;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(19))
            0: now_t = $urandom;
            1, 2: now_t = now_t + $urandom_range(100000, 400000);
            default: now_t = now_t + $urandom_range(0, 5000);
         endcase
         if ($urandom_range(99) < 15) r = sweep(now_t);
         else if ($urandom_range(99) < 80) r = sighting(key_pool[$urandom_range(95)], now_t);
         else r = sighting({$urandom, $urandom}, now_t);
         if ($urandom_range(19) == 0) r.now_ms = now_t - $urandom_range(1, 50000);
         send_request(r);
      end
   endtask

   initial begin
      req_type r;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, update, sweep, negative age
      r = sighting('0, 32'd0);
      r.signal_strength = -8'sd128;
      r.session_count = '0;
      r.total_count = '0;
      send_request(r);
      r = sighting('1, 32'hFFFF_FFFF);
      r.signal_strength = 8'sd127;
      r.session_count = '1;
      r.total_count = '1;
      send_request(r);
      send_request(sighting('0, 32'd5));
      send_request(sweep(32'd200000));
      send_request(sighting('1, 32'd200001));
      send_request(sweep(32'd100));
      send_request(sweep(32'hFFFF_FFFF));
      send_request(sweep(32'h7FFF_FFFF));
      drain;
      write_reg(CSR_THRESHOLD, '0);
      write_reg(CSR_NOTIFY, 31'd1);
      send_request(sighting(key_pool[0], 32'd300000));
      send_request(sweep(32'd300001));
      send_request(sighting(key_pool[0], 32'd300002));
      send_request(sweep(32'd300002));

      // random phases under several register settings
      random_items(200);
      drain;
      write_reg(CSR_THRESHOLD, 31'h7FFF_FFFF);
      write_reg(CSR_NOTIFY, 31'd0);
      quiet = 1'b1;
      random_items(150);
      quiet = 1'b0;
      drain;
      write_reg(CSR_THRESHOLD, 31'($urandom_range(1000, 200000)));
      write_reg(CSR_NOTIFY, 31'd1);
      random_items(200);
      drain;
      write_reg(CSR_THRESHOLD, 31'd20000);
      random_items(130);

      // full table with every last-seen time maximal: entry 0 goes
      drain;
      write_reg(CSR_THRESHOLD, 31'h7FFF_FFFF);
      for (int i = 0; i < TABLE_DEPTH + 2; i++)
         send_request(sighting({32'hA5A5_0000, 32'(i)}, 32'hFFFF_FFFF));

      drain;
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule

[peer_table_with_aging_top.f]
hdl/pta_pkg.sv
hdl/pta_ram.sv
hdl/peer_table_with_aging_top.sv
verif/tb_top.sv
